>>> src/mcfs_pkg.sv
package mcfs_pkg;

   // Default store size in bytes
   localparam int STORE_BYTES_DEF = 128;

   localparam int INDEX_W = 7;
   localparam int MASK_W  = 16;
   localparam int BYTE_W  = 8;
   localparam int SHIFT_W = 4;

   // Request kinds carried on the request tuser
   typedef enum logic [1:0] {
      REQ_READ  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   // Count of trailing zero bits; zero mask gives zero
   function automatic logic [SHIFT_W-1:0] trailing_zeros(input logic [MASK_W-1:0] m);
      logic [SHIFT_W-1:0] n;
      n = '0;
      for (int i = MASK_W - 1; i >= 0; i--) begin
         if (m[i]) begin
            n = SHIFT_W'(i);
         end
      end
      return n;
   endfunction

endpackage

>>> src/masked_cmos_field_store_top.sv
// Byte store reached through masked bit fields. Each request word reads a field,
// writes a field (read-modify-write) or clears the whole store; each gives exactly one
// response word. A mask with a non-zero high byte selects a two-byte big-endian field
// starting at byte_index; the field is masked and right-aligned by the mask's trailing
// zero count, and writes use the same alignment. An access that would touch a byte past
// the end of the store sets range_error and leaves the store alone. One request word is
// taken every cycle unless a held response stalls stage 1; the store read is registered
// into stage 1, and the merge and write-back happen as the request moves on to the
// response register. Two byte banks (even and odd addresses) let a two-byte field be
// read and written together; each row carries a valid bit that reset and clear drop.
module masked_cmos_field_store_top #(
   parameter int STORE_BYTES = mcfs_pkg::STORE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [6:0] byte_index, [22:7] field_mask, [38:23] write_value
   input  logic [39:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] read_value
   output logic [15:0] rsp_tdata,
   // [0] range_error
   output logic [0:0]  rsp_tuser
);
   import mcfs_pkg::*;

   localparam int ROWS  = (STORE_BYTES + 1) / 2;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   // Request word fields
   logic [INDEX_W-1:0] in_idx;
   logic [MASK_W-1:0]  in_mask;
   logic [MASK_W-1:0]  in_val;
   logic [BYTE_W:0]    in_first;
   logic [BYTE_W:0]    in_second;
   logic [ROW_W-1:0]   in_row [2];

   assign in_idx    = req_tdata[6:0];
   assign in_mask   = req_tdata[22:7];
   assign in_val    = req_tdata[38:23];
   assign in_first  = {2'b00, in_idx};
   assign in_second = in_first + 9'd1;

   // Bank 0 takes the even one of the two addresses, bank 1 the odd one
   always_comb begin
      if (in_idx[0]) begin
         in_row[0] = in_second[ROW_W:1];
         in_row[1] = in_first[ROW_W:1];
      end else begin
         in_row[0] = in_first[ROW_W:1];
         in_row[1] = in_second[ROW_W:1];
      end
   end

   // Stage 1 registers
   logic                s1_valid_ff;
   req_kind_type        s1_kind_ff;
   logic [INDEX_W-1:0]  s1_idx_ff;
   logic [MASK_W-1:0]   s1_mask_ff;
   logic [MASK_W-1:0]   s1_val_ff;
   logic [ROW_W-1:0]    s1_row_ff [2];
   logic [BYTE_W-1:0]   rd_ff [2];
   logic                rv_ff [2];

   // Write committed on the edge that loaded stage 1 (not seen by its read)
   logic                fw_clear_ff;
   logic                fw_wen_ff [2];
   logic [ROW_W-1:0]    fw_row_ff [2];
   logic [BYTE_W-1:0]   fw_byte_ff [2];

   // Response register
   logic                rsp_valid_ff;
   logic [MASK_W-1:0]   rsp_data_ff;
   logic                rsp_err_ff;

   // Store
   logic [BYTE_W-1:0]   mem_ff [2][ROWS];
   logic [ROWS-1:0]     vld_ff [2];

   logic s1_adv;
   logic s1_load;

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign s1_load    = req_tvalid && req_tready;

   // Stage 1 merge logic
   logic [BYTE_W-1:0]  eff_byte [2];
   logic               hi_bank;
   logic               wide;
   logic [SHIFT_W-1:0] sh;
   logic [MASK_W-1:0]  m_eff;
   logic [MASK_W-1:0]  word;
   logic [MASK_W-1:0]  merged;
   logic [MASK_W-1:0]  rd_val;
   logic [BYTE_W:0]    last;
   logic               err;
   logic               do_write;
   logic               do_clear;
   logic               wen [2];
   logic [BYTE_W-1:0]  wbyte [2];

   always_comb begin
      for (int b = 0; b < 2; b++) begin
         if (fw_clear_ff) begin
            eff_byte[b] = '0;
         end else if (fw_wen_ff[b] && fw_row_ff[b] == s1_row_ff[b]) begin
            eff_byte[b] = fw_byte_ff[b];
         end else begin
            eff_byte[b] = rv_ff[b] ? rd_ff[b] : '0;
         end
      end

      hi_bank = s1_idx_ff[0];
      wide    = s1_mask_ff[15:8] != 8'h00;
      sh      = trailing_zeros(s1_mask_ff);
      m_eff   = wide ? s1_mask_ff : {8'h00, s1_mask_ff[7:0]};
      word    = wide ? {eff_byte[hi_bank], eff_byte[~hi_bank]} : {8'h00, eff_byte[hi_bank]};
      last    = {2'b00, s1_idx_ff} + {8'd0, wide};
      err     = (s1_kind_ff == REQ_READ || s1_kind_ff == REQ_WRITE)
                && (last >= 9'(STORE_BYTES));
      rd_val  = (s1_kind_ff == REQ_READ && !err) ? ((word & m_eff) >> sh) : '0;
      merged  = (word & ~m_eff) | ((s1_val_ff << sh) & m_eff);

      do_write = s1_adv && s1_kind_ff == REQ_WRITE && !err;
      do_clear = s1_adv && s1_kind_ff == REQ_CLEAR;

      // High byte goes to the first address, low byte to the next one
      wen[0]   = 1'b0;
      wen[1]   = 1'b0;
      wbyte[0] = merged[7:0];
      wbyte[1] = merged[7:0];
      if (wide) begin
         wen[hi_bank]    = do_write;
         wen[~hi_bank]   = do_write;
         wbyte[hi_bank]  = merged[15:8];
         wbyte[~hi_bank] = merged[7:0];
      end else begin
         wen[hi_bank]    = do_write;
         wbyte[hi_bank]  = merged[7:0];
      end
   end

   // Banks: registered read on load, write-back from stage 1
   for (genvar b = 0; b < 2; b++) begin : g_bank
      always_ff @(posedge clock) begin
         if (wen[b]) begin
            mem_ff[b][s1_row_ff[b]] <= wbyte[b];
         end
         if (s1_load) begin
            rd_ff[b] <= mem_ff[b][in_row[b]];
            rv_ff[b] <= vld_ff[b][in_row[b]];
         end
      end

      always_ff @(posedge clock) begin
         if (reset || do_clear) begin
            vld_ff[b] <= '0;
         end else if (wen[b]) begin
            vld_ff[b][s1_row_ff[b]] <= 1'b1;
         end
      end
   end

   // Stage 1 control and payload
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fw_clear_ff  <= 1'b0;
         fw_wen_ff[0] <= 1'b0;
         fw_wen_ff[1] <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= 1'b1;
            fw_clear_ff <= do_clear;
            for (int b = 0; b < 2; b++) begin
               fw_wen_ff[b] <= wen[b];
            end
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
      end
      if (s1_load) begin
         s1_kind_ff <= req_kind_type'(req_tuser);
         s1_idx_ff  <= in_idx;
         s1_mask_ff <= in_mask;
         s1_val_ff  <= in_val;
         for (int b = 0; b < 2; b++) begin
            s1_row_ff[b]  <= in_row[b];
            fw_row_ff[b]  <= s1_row_ff[b];
            fw_byte_ff[b] <= wbyte[b];
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_adv) begin
         rsp_data_ff <= rd_val;
         rsp_err_ff  <= err;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_err_ff;

endmodule
